[design/pip_pkg.sv]
package pip_pkg;

    // One stored polygon vertex or one test point, signed Q8.22 latitude and Q9.22 longitude degrees
    typedef struct packed {
        logic signed [29:0] lat;
        logic signed [30:0] lon;
    } vertex_t;

    // Item travelling down the chain of edge cells
    typedef struct packed {
        logic        valid;
        logic        is_point;
        logic [5:0]  slot;
        logic [15:0] tag;
        vertex_t     pt;
        vertex_t     prev;
        vertex_t     first;
        vertex_t     last;
        logic        parity;
    } item_t;

    // Cross-products of one edge test, held between the two halves of a cell
    typedef struct packed {
        logic               en;
        logic               d_pos;
        logic signed [62:0] lhs;
        logic signed [62:0] rhs;
    } xprod_t;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_TEST  = 1'b1;

    // Form both cross-products for the edge from vi to vj against point pt
    function automatic xprod_t edge_prod(input vertex_t pt, input vertex_t vi,
                                         input vertex_t vj);
        logic signed [31:0] d_lon;
        logic signed [31:0] p_lon;
        logic signed [30:0] d_lat;
        logic signed [30:0] p_lat;
        xprod_t             r;
        d_lon   = 32'($signed(vj.lon)) - 32'($signed(vi.lon));
        p_lon   = 32'($signed(pt.lon)) - 32'($signed(vi.lon));
        d_lat   = 31'($signed(vj.lat)) - 31'($signed(vi.lat));
        p_lat   = 31'($signed(pt.lat)) - 31'($signed(vi.lat));
        r.en    = ($signed(vi.lon) > $signed(pt.lon)) != ($signed(vj.lon) > $signed(pt.lon));
        r.d_pos = (d_lon > 32'sd0);
        r.lhs   = p_lat * d_lon;
        r.rhs   = d_lat * p_lon;
        return r;
    endfunction

    // Decide whether the point lies below the crossing, sign-aware
    function automatic logic cross_hit(input xprod_t x);
        logic hit;
        if (x.d_pos)
        begin
            hit = ($signed(x.lhs) < $signed(x.rhs));
        end
        else
        begin
            hit = ($signed(x.lhs) > $signed(x.rhs));
        end
        return x.en & hit;
    endfunction

endpackage

[design/pip_cell.sv]
module pip_cell
    import pip_pkg::*;
#(
    parameter int K = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [6:0]  n_eff,
    input  item_t       in_item,
    output item_t       out_item
);

    localparam logic HAS_EDGE = (K >= 1);

    vertex_t vtx_reg;
    item_t   a_item_reg;
    item_t   a_item_next;
    xprod_t  xp_reg;
    xprod_t  xp_next;
    item_t   b_item_reg;
    item_t   b_item_next;
    logic    in_range;
    logic    is_last;
    logic    wr_hit;

    assign in_range = (K < int'(n_eff));
    assign is_last  = (K == int'(n_eff) - 1);
    assign wr_hit   = in_item.valid && (in_item.is_point == MODE_WRITE)
                      && (int'(in_item.slot) == K);

    // Store this cell's vertex when a write item for its slot passes
    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            vtx_reg <= in_item.pt;
        end
    end

    // First half: record this cell's vertex in the item and form the cross-products
    always_comb
    begin
        a_item_next = in_item;
        xp_next     = edge_prod(in_item.pt, vtx_reg, in_item.prev);
        xp_next.en  = xp_next.en && HAS_EDGE && in_range
                      && in_item.valid && (in_item.is_point == MODE_TEST);
        if (in_item.is_point == MODE_TEST)
        begin
            a_item_next.prev = vtx_reg;
            if (K == 0)
            begin
                a_item_next.first = vtx_reg;
            end
            if (is_last)
            begin
                a_item_next.last = vtx_reg;
            end
        end
    end

    // Second half: toggle parity on a crossing
    always_comb
    begin
        b_item_next        = a_item_reg;
        b_item_next.parity = a_item_reg.parity ^ cross_hit(xp_reg);
    end

    // Advance items; reset drops only the valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_item_reg.valid <= 1'b0;
            b_item_reg.valid <= 1'b0;
        end
        else
        begin
            a_item_reg <= a_item_next;
            xp_reg     <= xp_next;
            b_item_reg <= b_item_next;
        end
    end

    assign out_item = b_item_reg;

endmodule

[design/pip_wrap.sv]
module pip_wrap
    import pip_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [6:0]  n_eff,
    input  item_t       in_item,
    output item_t       out_item
);

    item_t  a_item_reg;
    xprod_t xp_reg;
    xprod_t xp_next;
    item_t  b_item_reg;
    item_t  b_item_next;

    // First half: closing edge from the first vertex to the last one
    always_comb
    begin
        xp_next    = edge_prod(in_item.pt, in_item.first, in_item.last);
        xp_next.en = xp_next.en && (n_eff != 7'd0)
                     && in_item.valid && (in_item.is_point == MODE_TEST);
    end

    // Second half: toggle parity on a crossing
    always_comb
    begin
        b_item_next        = a_item_reg;
        b_item_next.parity = a_item_reg.parity ^ cross_hit(xp_reg);
    end

    // Advance items; reset drops only the valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_item_reg.valid <= 1'b0;
            b_item_reg.valid <= 1'b0;
        end
        else
        begin
            a_item_reg <= in_item;
            xp_reg     <= xp_next;
            b_item_reg <= b_item_next;
        end
    end

    assign out_item = b_item_reg;

endmodule

[design/point_in_polygon_test.sv]
// Throughput: one item per cycle, vertex writes and point tests alike; busy stays low.
// Each edge cell forms cross-products, then compares them in a registered second half; a closing cell ends the chain.
// Vertex writes travel the chain in order, so a point sees exactly the writes before it.
// Reset clears the vertex count and all in-flight items; vertex slots hold garbage until written.
// The receiver cannot stall: each result is shown for one cycle with done high.
module point_in_polygon_test
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               mode,
    input  logic [5:0]         vertex_index,
    input  logic [15:0]        point_index,
    input  logic signed [29:0] latitude,
    input  logic signed [30:0] longitude,
    input  logic               cfg_we,
    input  logic [6:0]         cfg_data,
    output logic               done,
    output logic               inside_res,
    output logic [15:0]        result_index
);

    localparam int LAT = 2 * MAX_VERTICES + 2;

    logic [6:0] count_reg;
    logic [6:0] n_eff;
    item_t      head_item;
    item_t      chain [MAX_VERTICES+1];
    item_t      tail_item;

    // Hold the vertex count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 7'd0;
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_data;
        end
    end

    // Saturate the count at the chain length
    assign n_eff = (int'(count_reg) > MAX_VERTICES) ? 7'(MAX_VERTICES) : count_reg;

    // The chain takes an item every cycle
    assign busy = 1'b0;

    // Build the item entering the chain
    always_comb
    begin
        head_item          = '0;
        head_item.valid    = start && !busy;
        head_item.is_point = mode;
        head_item.slot     = vertex_index;
        head_item.tag      = point_index;
        head_item.pt.lat   = latitude;
        head_item.pt.lon   = longitude;
    end

    assign chain[0] = head_item;

    // Chain of edge cells, one per vertex slot
    for (genvar k = 0; k < MAX_VERTICES; k++)
    begin : g_cell
        pip_cell #(
            .K (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .n_eff    (n_eff),
            .in_item  (chain[k]),
            .out_item (chain[k+1])
        );
    end

    // Close the polygon with the edge from the first to the last vertex
    pip_wrap u_wrap (
        .clk      (clk),
        .rst_n    (rst_n),
        .n_eff    (n_eff),
        .in_item  (chain[MAX_VERTICES]),
        .out_item (tail_item)
    );

    // Drive the result strobe for tested points only
    assign done         = tail_item.valid && (tail_item.is_point == MODE_TEST);
    assign inside_res   = tail_item.parity;
    assign result_index = tail_item.tag;

    // Each result stems from a test item accepted a fixed time earlier
    a_done_from_test: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && (mode == MODE_TEST), LAT))
        else $error("result without a matching test item");

    // The tag survives the whole chain
    a_tag_kept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result_index == $past(point_index, LAT)))
        else $error("result tag does not match its test item");

    // An empty polygon never reports inside
    a_empty_outside: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (n_eff == 7'd0)) |-> !inside_res)
        else $error("inside reported for an empty polygon");

endmodule

[tb/point_in_polygon_test_test.sv]
`timescale 1ns / 1ps

module point_in_polygon_test_test
    import pip_pkg::*;
();

    localparam int     MAX_VERTS    = 64;
    localparam int     PIPE_LATENCY = 2 * MAX_VERTS + 2;
    localparam int     CYCLE_LIMIT  = 300000;
    localparam int     RANDOM_ITEMS = 1350;
    localparam longint DEG          = 64'sd1 << 22;
    localparam longint LAT_MAX      = 90 * DEG;
    localparam longint LON_MAX      = 180 * DEG;

    // One item as offered on the command port
    typedef struct {
        logic               mode;
        logic [5:0]         slot;
        logic [15:0]        tag;
        logic signed [29:0] lat;
        logic signed [30:0] lon;
    } poly_op_t;

    // One expected point-test answer
    typedef struct {
        logic        hit;
        logic [15:0] tag;
    } poly_result_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               start        = 1'b0;
    logic               busy;
    logic               mode         = MODE_WRITE;
    logic [5:0]         vertex_index = '0;
    logic [15:0]        point_index  = '0;
    logic signed [29:0] latitude     = '0;
    logic signed [30:0] longitude    = '0;
    logic               cfg_we       = 1'b0;
    logic [6:0]         cfg_data     = '0;
    logic               done;
    logic               inside_res;
    logic [15:0]        result_index;

    // Items waiting to be sent, and answers waiting to arrive
    poly_op_t     pending[$];
    poly_result_t answers[$];

    // Own copy of the vertex store and the vertex count
    logic signed [29:0] poly_lat [MAX_VERTS];
    logic signed [30:0] poly_lon [MAX_VERTS];
    logic [6:0]         poly_count = '0;

    int unsigned sender_idle_pct = 0;
    int          cycle_count     = 0;
    int          errors          = 0;
    int          n_items         = 0;
    int          n_tests         = 0;
    int          n_inside        = 0;
    int          n_settings      = 0;

    point_in_polygon_test #(
        .MAX_VERTICES(MAX_VERTS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .vertex_index (vertex_index),
        .point_index  (point_index),
        .latitude     (latitude),
        .longitude    (longitude),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .done         (done),
        .inside_res   (inside_res),
        .result_index (result_index)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Even-odd parity over the edges of the stored polygon, exact cross-multiplication
    function automatic bit point_inside(input longint plat, input longint plon);
        int     n;
        int     j;
        bit     parity;
        longint lat_a;
        longint lon_a;
        longint lat_b;
        longint lon_b;
        longint d;
        longint lhs;
        longint rhs;
        n = (poly_count > MAX_VERTS) ? MAX_VERTS : int'(poly_count);
        parity = 1'b0;
        j = n - 1;
        for (int i = 0; i < n; i++)
        begin
            lat_a = poly_lat[i];
            lon_a = poly_lon[i];
            lat_b = poly_lat[j];
            lon_b = poly_lon[j];
            if ((lon_a > plon) != (lon_b > plon))
            begin
                d   = lon_b - lon_a;
                lhs = (plat - lat_a) * d;
                rhs = (lat_b - lat_a) * (plon - lon_a);
                if ((d > 0) ? (lhs < rhs) : (lhs > rhs))
                    parity = !parity;
            end
            j = i;
        end
        return parity;
    endfunction

    function automatic longint rand_around(input longint centre, input longint half,
                                           input longint limit);
        longint v;
        v = centre - half + longint'($urandom_range(32'(2 * half)));
        if (v > limit)
            v = limit;
        if (v < -limit)
            v = -limit;
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 30)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic push_vertex(input int slot, input longint lat, input longint lon);
        poly_op_t it;
        it.mode = MODE_WRITE;
        it.slot = 6'(slot);
        it.tag  = 16'($urandom);
        it.lat  = lat[29:0];
        it.lon  = lon[30:0];
        pending.push_back(it);
    endtask

    task automatic push_point(input longint lat, input longint lon, input logic [15:0] tag);
        poly_op_t it;
        it.mode = MODE_TEST;
        it.slot = 6'($urandom);
        it.tag  = tag;
        it.lat  = lat[29:0];
        it.lon  = lon[30:0];
        pending.push_back(it);
    endtask

    // Drain the pipeline fully, then write the vertex count
    task automatic set_vertex_count(input logic [6:0] value);
        while (pending.size() != 0 || answers.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 8) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        poly_count  = value;
        n_settings++;
    endtask

    // Driver: hold an item until taken, predict on acceptance, idle at random
    always @(posedge clk)
    begin : drive_items
        bit           go;
        bit           taken;
        poly_op_t     it;
        poly_result_t res;
        go = 1'b0;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            taken = start && !busy;
            if (taken)
            begin
                it = pending.pop_front();
                n_items++;
                if (it.mode == MODE_WRITE)
                begin
                    poly_lat[it.slot] = it.lat;
                    poly_lon[it.slot] = it.lon;
                end
                else
                begin
                    res.hit = point_inside(it.lat, it.lon);
                    res.tag = it.tag;
                    answers.push_back(res);
                    n_tests++;
                end
            end
            if (pending.size() != 0)
            begin
                if (start && !taken)
                    go = 1'b1;
                else
                    go = ($urandom_range(99) >= sender_idle_pct);
            end
            start <= go;
            if (go)
            begin
                mode         <= pending[0].mode;
                vertex_index <= pending[0].slot;
                point_index  <= pending[0].tag;
                latitude     <= pending[0].lat;
                longitude    <= pending[0].lon;
            end
        end
    end

    // Monitor: check each strobed result against the oldest answer
    always @(posedge clk)
    begin : check_results
        poly_result_t want;
        if (rst_n && done)
        begin
            if (answers.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result tag %h", result_index));
            end
            else
            begin
                want = answers.pop_front();
                if (want.hit)
                    n_inside++;
                if (result_index !== want.tag)
                    report_mismatch($sformatf("result_index %h, want %h",
                                              result_index, want.tag));
                if (inside_res !== want.hit)
                    report_mismatch($sformatf("inside_res %b, want %b (tag %h)",
                                              inside_res, want.hit, want.tag));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles with %0d answers outstanding",
                     cycle_count, answers.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned idle_plan [4];
        longint      shape_lat [MAX_VERTS];
        longint      shape_lon [MAX_VERTS];
        longint      sq;
        longint      clat;
        longint      clon;
        longint      hlat;
        longint      hlon;
        longint      plat;
        longint      plon;
        int          shape_n;
        int          count;
        int          phase;
        int          pushed;
        int          top;
        int          bottom;
        int          mix;
        int          sel;
        int          k;
        idle_plan = '{0, 59, 0, 17};
        sq        = 10 * DEG;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero vertices: always outside
        push_point(LAT_MAX, LON_MAX, 16'h0000);
        push_point(-LAT_MAX, -LON_MAX, 16'hFFFF);

        // One vertex: no edge can straddle
        set_vertex_count(7'd1);
        push_vertex(0, 0, 0);
        push_point(-DEG, 0, 16'h0001);

        // Two vertices: both edges straddle, parity cancels
        set_vertex_count(7'd2);
        push_vertex(1, LAT_MAX, LON_MAX);
        push_point(-LAT_MAX, DEG, 16'h0002);

        // Square: centre, edges, corner, outside and the latitude extremes
        set_vertex_count(7'd4);
        push_vertex(0, -sq, -sq);
        push_vertex(1, -sq, sq);
        push_vertex(2, sq, sq);
        push_vertex(3, sq, -sq);
        push_point(0, 0, 16'h0003);
        push_point(0, -sq, 16'h0004);
        push_point(-sq, -sq, 16'h0005);
        push_point(0, 2 * sq, 16'h0006);
        push_point(sq, 0, 16'h0007);
        push_point(-sq - 1, 0, 16'h0008);
        push_point(LAT_MAX, 0, 16'h0009);
        push_point(-LAT_MAX, 0, 16'h000A);

        // Random phases: new count, new polygon, then mostly tests near it
        phase  = 0;
        pushed = 0;
        while (pushed < RANDOM_ITEMS)
        begin
            case (phase)
                0: count = MAX_VERTS;
                1: count = 127;
                2: count = 0;
                default:
                begin
                    sel = $urandom_range(19);
                    if (sel == 0)
                        count = 0;
                    else if (sel == 1)
                        count = 1;
                    else if (sel == 2)
                        count = 2;
                    else if (sel == 3)
                        count = MAX_VERTS;
                    else if (sel == 4)
                        count = $urandom_range(127, MAX_VERTS + 1);
                    else
                        count = $urandom_range(15, 3);
                end
            endcase
            set_vertex_count(7'(count));
            sender_idle_pct = idle_plan[phase % 4];
            shape_n = (count > MAX_VERTS) ? MAX_VERTS : count;

            // Pick a bounding box: mostly small, sometimes the whole globe
            sel = $urandom_range(9);
            if (sel < 5)
            begin
                hlat = DEG * $urandom_range(20, 1);
                hlon = DEG * $urandom_range(20, 1);
            end
            else if (sel < 8)
            begin
                hlat = DEG * $urandom_range(80, 20);
                hlon = DEG * $urandom_range(170, 20);
            end
            else
            begin
                hlat = LAT_MAX;
                hlon = LON_MAX;
            end
            clat = rand_around(0, LAT_MAX - hlat, LAT_MAX);
            clon = rand_around(0, LON_MAX - hlon, LON_MAX);

            // Build either a comb-shaped simple polygon or a random tangle
            top    = (shape_n + 1) / 2;
            bottom = shape_n - top;
            sel    = $urandom_range(1);
            for (int v = 0; v < shape_n; v++)
            begin
                if (sel == 0)
                begin
                    shape_lat[v] = rand_around(clat, hlat, LAT_MAX);
                    shape_lon[v] = rand_around(clon, hlon, LON_MAX);
                end
                else if (v < top)
                begin
                    shape_lon[v] = clon - hlon + ((top > 1) ? 2 * hlon * v / (top - 1) : 0);
                    shape_lat[v] = rand_around(clat + hlat / 2, hlat / 2, LAT_MAX);
                end
                else
                begin
                    k = v - top;
                    shape_lon[v] = clon + hlon
                                   - ((bottom > 1) ? 2 * hlon * k / (bottom - 1) : 0);
                    shape_lat[v] = rand_around(clat - hlat / 2, hlat / 2, LAT_MAX);
                end
                if ($urandom_range(19) == 0)
                    shape_lat[v] = $urandom_range(1) ? LAT_MAX : -LAT_MAX;
                if ($urandom_range(19) == 0)
                    shape_lon[v] = $urandom_range(1) ? LON_MAX : -LON_MAX;
                push_vertex(v, shape_lat[v], shape_lon[v]);
            end
            pushed += shape_n;

            // Mixed stream: tests in and around the box, ties on vertex coordinates,
            // stray tests anywhere and vertex rewrites
            mix = $urandom_range(70, 20);
            for (int m = 0; m < mix; m++)
            begin
                sel = $urandom_range(99);
                if (sel < 8)
                begin
                    k = $urandom_range(MAX_VERTS - 1);
                    plat = rand_around(clat, hlat, LAT_MAX);
                    plon = rand_around(clon, hlon, LON_MAX);
                    if (k < shape_n)
                    begin
                        shape_lat[k] = plat;
                        shape_lon[k] = plon;
                    end
                    push_vertex(k, plat, plon);
                end
                else if (sel < 14)
                begin
                    push_point(rand_around(0, LAT_MAX, LAT_MAX),
                               rand_around(0, LON_MAX, LON_MAX), 16'($urandom));
                end
                else
                begin
                    plat = rand_around(clat, hlat + hlat / 4, LAT_MAX);
                    plon = rand_around(clon, hlon + hlon / 4, LON_MAX);
                    if (shape_n > 0)
                    begin
                        k   = $urandom_range(shape_n - 1);
                        sel = $urandom_range(9);
                        if (sel < 2 || sel == 3)
                            plon = shape_lon[k];
                        if (sel == 2 || sel == 3)
                            plat = shape_lat[k];
                    end
                    push_point(plat, plon, 16'($urandom));
                end
            end
            pushed += mix;
            phase++;
        end

        // Let everything drain, plus the pipeline depth for stray results
        while (pending.size() != 0 || answers.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 10) @(posedge clk);

        $display("Sent %0d items over %0d vertex-count settings (0 up to 127).",
                 n_items, n_settings);
        $display("Checked %0d point tests, %0d of them inside.", n_tests, n_inside);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
